// File: rtl/core/led_blink_table_controller_assert.svh
// ---------------------------------------------------------------------------
// led blink table controller assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef LED_BLINK_TABLE_CONTROLLER_ASSERT_SVH
`define LED_BLINK_TABLE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define LBT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lbt_pkg.sv
// ---------------------------------------------------------------------------
// lbt_pkg
// types, codes and constants of the led blink table controller
// ---------------------------------------------------------------------------
`default_nettype none

package lbt_pkg;

    localparam int ENTRIES_DEF = 8;
    localparam int RESULT_CAP  = 8;
    localparam int NRES_W      = $clog2(RESULT_CAP + 1);

    localparam logic [15:0] TASK_PERIOD_RST = 16'd10;
    localparam logic [16:0] TICK_MAX        = 17'h1FFFF;
    localparam logic [7:0]  COUNT_FOREVER   = 8'd255;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_BLINK = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_ON     = 2'd1;
    localparam logic [1:0] MODE_TOGGLE = 2'd2;

    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_TOGGLE = 2'd2;

    localparam logic KIND_ACTION = 1'b0;
    localparam logic KIND_FULL   = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  port_id;
        logic [31:0] led_mask;
        logic [1:0]  set_mode;
        logic [7:0]  blink_count;
        logic [6:0]  duty_percent;
        logic [15:0] blink_period_ms;
    } t_cmd;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  out_port;
        logic [31:0] out_mask;
        logic [1:0]  pin_action;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [7:0]  port;
        logic [31:0] mask;
        logic [16:0] ticks;
        logic [15:0] period;
        logic [7:0]  count;
        logic [6:0]  duty;
    } t_entry;

    typedef struct packed {
        logic   wr;
        logic   off;
        t_entry ent;
    } t_tick_wb;

endpackage

`default_nettype wire

// File: rtl/core/lbt_table.sv
// ---------------------------------------------------------------------------
// lbt_table
// entry memory with registered read and per-entry live bits
// ---------------------------------------------------------------------------
`default_nettype none

module lbt_table #(
    parameter int  ENTRIES = lbt_pkg::ENTRIES_DEF,
    localparam int IDXW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDXW-1:0]  i_rd_addr,
    output lbt_pkg::t_entry       o_rd_data,
    output logic                  o_rd_live,
    input  wire logic             i_wr_en,
    input  wire logic [IDXW-1:0]  i_wr_addr,
    input  wire lbt_pkg::t_entry  i_wr_data,
    input  wire logic             i_clr_en,
    input  wire logic [IDXW-1:0]  i_clr_addr
);
    import lbt_pkg::*;

    t_entry               r_mem [ENTRIES];
    logic [ENTRIES-1:0]   r_live;
    t_entry               r_rd_data;
    logic                 r_rd_live;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_rd_live <= 1'b0;
        end else begin
            r_rd_live <= r_live[i_rd_addr];
            if (i_wr_en) begin
                r_live[i_wr_addr] <= 1'b1;
            end else if (i_clr_en) begin
                r_live[i_clr_addr] <= 1'b0;
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_live = r_rd_live;

endmodule

`default_nettype wire

// File: rtl/core/lbt_tick_unit.sv
// ---------------------------------------------------------------------------
// lbt_tick_unit
// three-stage tick update: advance, multiply, scale and compare
// ---------------------------------------------------------------------------
`default_nettype none

module lbt_tick_unit #(
    parameter int  ENTRIES = lbt_pkg::ENTRIES_DEF,
    localparam int IDXW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_vld,
    input  wire logic [IDXW-1:0]  i_idx,
    input  wire logic             i_live,
    input  wire lbt_pkg::t_entry  i_ent,
    input  wire logic [15:0]      i_task_period,
    output logic                  o_busy,
    output lbt_pkg::t_tick_wb     o_wb,
    output logic [IDXW-1:0]       o_idx
);
    import lbt_pkg::*;

    logic             r_s1_vld, r_s2_vld, r_s3_vld;
    logic             r_s1_act, r_s2_act, r_s3_act;
    t_entry           r_s1_ent, r_s2_ent, r_s3_ent;
    logic [IDXW-1:0]  r_s1_idx, r_s2_idx, r_s3_idx;
    logic [32:0]      r_s2_elapsed;
    logic [22:0]      r_s2_prod, r_s3_prod;
    logic [39:0]      r_s3_e100;
    logic             r_s3_done;

    logic             n_act;
    t_entry           n_ent;
    logic [39:0]      n_el_ext;

    always_comb begin
        n_act = i_live && (i_ent.mask != 32'd0) && (i_ent.count != 8'd0);
        n_ent = i_ent;
        if (i_ent.ticks < TICK_MAX) begin
            n_ent.ticks = i_ent.ticks + 17'd1;
        end
        n_el_ext = {7'd0, r_s2_elapsed};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_act     <= n_act;
        r_s1_ent     <= n_ent;
        r_s1_idx     <= i_idx;

        r_s2_act     <= r_s1_act;
        r_s2_ent     <= r_s1_ent;
        r_s2_idx     <= r_s1_idx;
        r_s2_elapsed <= {16'd0, r_s1_ent.ticks} * {17'd0, i_task_period};
        r_s2_prod    <= {7'd0, r_s1_ent.period} * {16'd0, r_s1_ent.duty};

        r_s3_act     <= r_s2_act;
        r_s3_ent     <= r_s2_ent;
        r_s3_idx     <= r_s2_idx;
        r_s3_prod    <= r_s2_prod;
        r_s3_e100    <= (n_el_ext << 6) + (n_el_ext << 5) + (n_el_ext << 2);
        r_s3_done    <= r_s2_elapsed >= {17'd0, r_s2_ent.period};
    end

    always_comb begin
        o_wb.wr  = r_s3_vld && r_s3_act;
        o_wb.off = r_s3_e100 >= {17'd0, r_s3_prod};
        o_wb.ent = r_s3_ent;
        if (r_s3_done) begin
            o_wb.ent.ticks = '0;
            if (r_s3_ent.count != COUNT_FOREVER) begin
                o_wb.ent.count = r_s3_ent.count - 8'd1;
            end
        end
    end

    assign o_idx  = r_s3_idx;
    assign o_busy = r_s1_vld || r_s2_vld || r_s3_vld;

endmodule

`default_nettype wire

// File: rtl/core/led_blink_table_controller.sv
// ---------------------------------------------------------------------------
// led_blink_table_controller
// table of blinking active-low led groups with set, blink and tick commands
// ---------------------------------------------------------------------------
// Every accepted tick word, and every set or blink word on a nonzero port,
// walks the entry memory through its single read port, one entry per cycle.
// Busy then stays high while the memory read and, for tick words, the
// three-stage tick arithmetic drain. Set and blink words with port zero
// and no-op words are accepted without a walk and leave busy low. Result
// words leave one per cycle on o_res_strobe and must be taken when shown;
// the receiver cannot stall them. The final word of an item may appear
// once busy is low again, alongside the next accept. The config write
// port is ready whenever busy is low. No clearing pass follows reset.
// ---------------------------------------------------------------------------
`default_nettype none

module led_blink_table_controller #(
    parameter int ENTRIES = lbt_pkg::ENTRIES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire lbt_pkg::t_cmd i_cmd,
    output logic              o_res_strobe,
    output lbt_pkg::t_res     o_res,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [15:0]  i_cfg_data
);
    import lbt_pkg::*;

    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [IDXW-1:0]    r_idx, n_idx;
    t_cmd               r_cmd;
    logic [15:0]        r_task_period;
    logic               r_rd_vld;
    logic [IDXW-1:0]    r_rd_addr;
    logic               r_match_fnd, r_free_fnd;
    logic [IDXW-1:0]    r_match_idx, r_free_idx;
    logic               r_out_vld, n_out_vld;
    t_res               r_out, n_out;
    logic               r_hold_vld, n_hold_vld;
    t_res               r_hold, n_hold;
    logic [NRES_W-1:0]  r_nres, n_nres;

    logic               acc;
    logic               useful;
    t_entry             rd_data;
    logic               rd_live;
    logic               hit;
    logic               clr_en;
    logic               blink_wr;
    logic               wr_en;
    logic [IDXW-1:0]    wr_addr;
    t_entry             wr_data;
    t_entry             blink_ent;
    logic               tk_busy;
    t_tick_wb           tk_wb;
    logic [IDXW-1:0]    tk_idx;
    logic [1:0]         set_act;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = !busy;
    assign acc         = start && !busy;
    assign useful      = (i_cmd.opcode == OP_TICK) ||
                         (((i_cmd.opcode == OP_SET) || (i_cmd.opcode == OP_BLINK)) &&
                          (i_cmd.port_id != 8'd0));

    assign hit    = rd_live && (rd_data.port == r_cmd.port_id) &&
                    (rd_data.mask == r_cmd.led_mask);
    assign clr_en = r_rd_vld && (r_cmd.opcode == OP_SET) && hit;

    assign blink_wr = (r_state == ST_FIN) && (r_cmd.opcode == OP_BLINK) &&
                      (r_match_fnd || r_free_fnd);

    always_comb begin
        blink_ent.port   = r_cmd.port_id;
        blink_ent.mask   = r_cmd.led_mask;
        blink_ent.ticks  = '0;
        blink_ent.period = r_cmd.blink_period_ms;
        blink_ent.count  = r_cmd.blink_count;
        blink_ent.duty   = r_cmd.duty_percent;
        wr_en   = tk_wb.wr || blink_wr;
        wr_addr = tk_idx;
        wr_data = tk_wb.ent;
        if (!tk_wb.wr) begin
            wr_addr = r_match_fnd ? r_match_idx : r_free_idx;
            wr_data = blink_ent;
        end
    end

    always_comb begin
        case (r_cmd.set_mode)
            MODE_ON:     set_act = ACT_CLEAR;
            MODE_TOGGLE: set_act = ACT_TOGGLE;
            default:     set_act = ACT_SET;
        endcase
    end

    lbt_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (r_idx),
        .o_rd_data  (rd_data),
        .o_rd_live  (rd_live),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_clr_en   (clr_en),
        .i_clr_addr (r_rd_addr)
    );

    lbt_tick_unit #(
        .ENTRIES (ENTRIES)
    ) u_tick (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (r_rd_vld && (r_cmd.opcode == OP_TICK)),
        .i_idx         (r_rd_addr),
        .i_live        (rd_live),
        .i_ent         (rd_data),
        .i_task_period (r_task_period),
        .o_busy        (tk_busy),
        .o_wb          (tk_wb),
        .o_idx         (tk_idx)
    );

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_out_vld  = 1'b0;
        n_out      = r_out;
        n_hold     = r_hold;
        n_hold_vld = r_hold_vld;
        n_nres     = r_nres;

        unique case (r_state)
            ST_IDLE: begin
                if (acc && useful) begin
                    n_state    = ST_WALK;
                    n_idx      = '0;
                    n_nres     = '0;
                    n_hold_vld = 1'b0;
                end
            end
            ST_WALK: begin
                if (r_idx == IDXW'(ENTRIES - 1)) begin
                    n_state = ST_WAIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_WAIT: begin
                if (!r_rd_vld && !tk_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
                unique case (r_cmd.opcode)
                    OP_SET: begin
                        n_out_vld        = 1'b1;
                        n_out.result_kind = KIND_ACTION;
                        n_out.out_port   = r_cmd.port_id;
                        n_out.out_mask   = r_cmd.led_mask;
                        n_out.pin_action = set_act;
                        n_out.last       = 1'b1;
                    end
                    OP_BLINK: begin
                        if (!r_match_fnd && !r_free_fnd) begin
                            n_out_vld         = 1'b1;
                            n_out.result_kind = KIND_FULL;
                            n_out.out_port    = '0;
                            n_out.out_mask    = '0;
                            n_out.pin_action  = ACT_SET;
                            n_out.last        = 1'b1;
                        end
                    end
                    OP_TICK: begin
                        if (r_hold_vld) begin
                            n_out_vld  = 1'b1;
                            n_out      = r_hold;
                            n_out.last = 1'b1;
                            n_hold_vld = 1'b0;
                        end
                    end
                    default: begin
                        n_out_vld = 1'b0;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (tk_wb.wr && (r_nres < NRES_W'(RESULT_CAP))) begin
            if (r_hold_vld) begin
                n_out_vld  = 1'b1;
                n_out      = r_hold;
                n_out.last = 1'b0;
            end
            n_hold.result_kind = KIND_ACTION;
            n_hold.out_port    = tk_wb.ent.port;
            n_hold.out_mask    = tk_wb.ent.mask;
            n_hold.pin_action  = tk_wb.off ? ACT_SET : ACT_CLEAR;
            n_hold.last        = 1'b0;
            n_hold_vld         = 1'b1;
            n_nres             = r_nres + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_idx         <= '0;
            r_task_period <= TASK_PERIOD_RST;
            r_rd_vld      <= 1'b0;
            r_match_fnd   <= 1'b0;
            r_free_fnd    <= 1'b0;
            r_out_vld     <= 1'b0;
            r_hold_vld    <= 1'b0;
            r_nres        <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_rd_vld   <= (r_state == ST_WALK);
            r_out_vld  <= n_out_vld;
            r_hold_vld <= n_hold_vld;
            r_nres     <= n_nres;
            if (i_cfg_valid && o_cfg_ready) begin
                r_task_period <= i_cfg_data;
            end
            if (acc) begin
                r_match_fnd <= 1'b0;
                r_free_fnd  <= 1'b0;
            end else if (r_rd_vld && (r_cmd.opcode == OP_BLINK)) begin
                if (hit && !r_match_fnd) begin
                    r_match_fnd <= 1'b1;
                end
                if (!rd_live && !r_free_fnd) begin
                    r_free_fnd <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_hold    <= n_hold;
        r_rd_addr <= r_idx;
        if (acc) begin
            r_cmd <= i_cmd;
        end
        if (r_rd_vld && hit && !r_match_fnd) begin
            r_match_idx <= r_rd_addr;
        end
        if (r_rd_vld && !rd_live && !r_free_fnd) begin
            r_free_idx <= r_rd_addr;
        end
    end

    assign o_res_strobe = r_out_vld;
    assign o_res        = r_out;

endmodule

`default_nettype wire

// File: rtl/core/lbt_checker.sv
// ---------------------------------------------------------------------------
// lbt_checker
// port-level checks of the led blink table controller
// ---------------------------------------------------------------------------
`default_nettype none

`include "led_blink_table_controller_assert.svh"

module lbt_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire lbt_pkg::t_cmd i_cmd,
    input  wire logic          o_res_strobe,
    input  wire lbt_pkg::t_res o_res
);
    import lbt_pkg::*;

    // a table-full error is always a lone word
    `LBT_ASSERT_SAME(a_full_last, o_res_strobe && (o_res.result_kind == KIND_FULL), o_res.last, "table full word without last")
    // error words carry empty fields
    `LBT_ASSERT_SAME(a_full_empty, o_res_strobe && (o_res.result_kind == KIND_FULL), (o_res.out_port == 8'd0) && (o_res.out_mask == 32'd0) && (o_res.pin_action == ACT_SET), "table full word with fields set")
    // a set word on a real port starts a table walk
    `LBT_ASSERT_NEXT(a_set_walk, start && !busy && (i_cmd.opcode == OP_SET) && (i_cmd.port_id != 8'd0), busy, "set word did not start a walk")
    // busy only rises after a start
    `LBT_ASSERT_SAME(a_busy_cause, $rose(busy), $past(start), "busy rose without start")

endmodule

bind led_blink_table_controller lbt_checker u_lbt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_cmd        (i_cmd),
    .o_res_strobe (o_res_strobe),
    .o_res        (o_res)
);

`default_nettype wire
